>>> hdl/lfrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrs_pkg
// Shared types and fixed field widths of the lowest free room scheduler.
// ----------------------------------------------------------------------------
package lfrs_pkg;

    localparam int CNT_BITS      = 16;
    localparam int CFG_BITS      = 5;
    localparam int IN_TIME_BITS  = 32;
    localparam int OUT_TIME_BITS = 48;
    localparam int OUT_ROOM_BITS = 4;

    localparam logic [CNT_BITS-1:0] CNT_MAX   = '1;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

    localparam logic MODE_SCHED = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_WAIT   = 5'b00100,
        ST_COMMIT = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    typedef struct packed {
        logic start;
        logic eval;
    } scan_ctl_t;

endpackage

>>> hdl/lfrs_job_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrs_job_if
// Job channel: valid/ready handshake with mode, start and end time.
// ----------------------------------------------------------------------------
interface lfrs_job_if
    import lfrs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [IN_TIME_BITS-1:0] start_time;
    logic [IN_TIME_BITS-1:0] end_time;

    modport source (output valid, output mode, output start_time, output end_time,
                    input ready);
    modport sink   (input valid, input mode, input start_time, input end_time,
                    output ready);
endinterface

>>> hdl/lfrs_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrs_res_if
// Result channel: valid/ready handshake with the scheduling result fields.
// ----------------------------------------------------------------------------
interface lfrs_res_if
    import lfrs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OUT_ROOM_BITS-1:0] assigned_room;
    logic [OUT_TIME_BITS-1:0] actual_start;
    logic                     was_delayed;
    logic [OUT_ROOM_BITS-1:0] busiest_room;
    logic [CNT_BITS-1:0]      busiest_count;
    logic                     bad_job;

    modport source (output valid, output assigned_room, output actual_start,
                    output was_delayed, output busiest_room, output busiest_count,
                    output bad_job, input ready);
    modport sink   (input valid, input assigned_room, input actual_start,
                    input was_delayed, input busiest_room, input busiest_count,
                    input bad_job, output ready);
endinterface

>>> hdl/lfrs_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrs_store
// Per-room free time and use count memory with valid bits; registered read.
// ----------------------------------------------------------------------------
module lfrs_store
    import lfrs_pkg::*;
#(
    parameter int ROOMS     = 16,
    parameter int TIME_BITS = 48,
    parameter int IDX_BITS  = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 wr_en,
    input  logic [IDX_BITS-1:0]  wr_addr,
    input  logic [TIME_BITS-1:0] wr_time,
    input  logic [CNT_BITS-1:0]  wr_cnt,
    input  logic [IDX_BITS-1:0]  rd_addr,
    output logic [TIME_BITS-1:0] rd_time,
    output logic [CNT_BITS-1:0]  rd_cnt
);

    logic [TIME_BITS-1:0] time_mem [ROOMS];
    logic [CNT_BITS-1:0]  cnt_mem  [ROOMS];
    logic [ROOMS-1:0]     valid_reg;
    logic [TIME_BITS-1:0] rd_time_reg;
    logic [CNT_BITS-1:0]  rd_cnt_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_addr] <= wr_time;
            cnt_mem[wr_addr]  <= wr_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_time_reg  <= time_mem[rd_addr];
        rd_cnt_reg   <= cnt_mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    assign rd_time = rd_valid_reg ? rd_time_reg : '0;
    assign rd_cnt  = rd_valid_reg ? rd_cnt_reg  : '0;

endmodule

>>> hdl/lfrs_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrs_scan
// Compare unit applied to one room per cycle: first free room, earliest
// freeing room and busiest room of the rooms in use.
// ----------------------------------------------------------------------------
module lfrs_scan
    import lfrs_pkg::*;
#(
    parameter int TIME_BITS = 48,
    parameter int IDX_BITS  = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  scan_ctl_t            ctl,
    input  logic [IDX_BITS-1:0]  idx,
    input  logic [TIME_BITS-1:0] room_time,
    input  logic [CNT_BITS-1:0]  room_cnt,
    input  logic [TIME_BITS-1:0] start_time,
    output logic                 found,
    output logic [IDX_BITS-1:0]  first_room,
    output logic [CNT_BITS-1:0]  first_cnt,
    output logic [IDX_BITS-1:0]  min_room,
    output logic [TIME_BITS-1:0] min_time,
    output logic [CNT_BITS-1:0]  min_cnt,
    output logic [IDX_BITS-1:0]  best_room,
    output logic [CNT_BITS-1:0]  best_cnt
);

    logic                 found_reg;
    logic [IDX_BITS-1:0]  first_room_reg;
    logic [CNT_BITS-1:0]  first_cnt_reg;
    logic [IDX_BITS-1:0]  min_room_reg;
    logic [TIME_BITS-1:0] min_time_reg;
    logic [CNT_BITS-1:0]  min_cnt_reg;
    logic [IDX_BITS-1:0]  best_room_reg;
    logic [CNT_BITS-1:0]  best_cnt_reg;
    logic                 is_first;
    logic                 hit_free;
    logic                 hit_min;
    logic                 hit_best;

    assign is_first = (idx == '0);
    assign hit_free = !found_reg && (room_time <= start_time);
    assign hit_min  = is_first || (room_time < min_time_reg);
    assign hit_best = is_first || (room_cnt > best_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.eval && hit_free)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.eval)
        begin
            if (hit_free)
            begin
                first_room_reg <= idx;
                first_cnt_reg  <= room_cnt;
            end
            if (hit_min)
            begin
                min_room_reg <= idx;
                min_time_reg <= room_time;
                min_cnt_reg  <= room_cnt;
            end
            if (hit_best)
            begin
                best_room_reg <= idx;
                best_cnt_reg  <= room_cnt;
            end
        end
    end

    assign found      = found_reg;
    assign first_room = first_room_reg;
    assign first_cnt  = first_cnt_reg;
    assign min_room   = min_room_reg;
    assign min_time   = min_time_reg;
    assign min_cnt    = min_cnt_reg;
    assign best_room  = best_room_reg;
    assign best_cnt   = best_cnt_reg;

endmodule

>>> hdl/lowest_free_room_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_free_room_scheduler_core
// Assigns jobs to the lowest free room or delays them to the earliest
// freeing room, keeping per-room free time and use count.
// ----------------------------------------------------------------------------
// Usage:
//   job_ch carries one item per job: mode, start_time, end_time. mode 0
//   schedules the job, mode 1 clears all free times and counts.
//   res_ch returns exactly one item per job, in order.
//   cfg_we/cfg_wdata write rooms_in_use (0 acts as 1, above ROOMS as ROOMS);
//   write it only while no job is in flight.
//   A scheduled job goes from acceptance to the result register through
//   one store read per room, K being the active room count, each read
//   passing through the single compare unit, then a wait state for the
//   read latency, a commit and the unload. A clear item goes straight to
//   the unload. job_ch.ready is high only when idle, so one job is in
//   flight at a time.
//   The result register holds a finished item while res_ch stalls; the next
//   job is accepted and scanned meanwhile and waits for the register.
//   Reset empties the store (free times and counts read as zero), drops
//   any pending result and sets rooms_in_use to 16.
// ----------------------------------------------------------------------------
module lowest_free_room_scheduler_core
    import lfrs_pkg::*;
#(
    parameter int ROOMS     = 16,
    parameter int TIME_BITS = 48
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    lfrs_job_if.sink            job_ch,
    lfrs_res_if.source          res_ch
);

    localparam int IDX_BITS = (ROOMS > 1) ? $clog2(ROOMS) : 1;
    localparam logic [6:0] ROOMS_W = 7'(ROOMS);

    state_t state_reg, state_next;

    logic [CFG_BITS-1:0]     rooms_in_use_reg;
    logic [6:0]              active_cnt;
    logic [IDX_BITS-1:0]     last_idx;

    logic [IDX_BITS-1:0]     addr_reg, addr_next;
    logic                    eval_reg;
    logic [IDX_BITS-1:0]     eval_idx_reg;

    logic [IN_TIME_BITS-1:0] st_reg;
    logic [IN_TIME_BITS-1:0] en_reg;
    logic                    bad_reg;

    logic [IDX_BITS-1:0]     res_room_reg;
    logic [TIME_BITS-1:0]    res_actual_reg;
    logic                    res_delayed_reg;
    logic [IDX_BITS-1:0]     res_best_room_reg;
    logic [CNT_BITS-1:0]     res_best_cnt_reg;
    logic                    res_bad_reg;

    logic                     out_valid_reg;
    logic [OUT_ROOM_BITS-1:0] out_room_reg;
    logic [OUT_TIME_BITS-1:0] out_actual_reg;
    logic                     out_delayed_reg;
    logic [OUT_ROOM_BITS-1:0] out_best_room_reg;
    logic [CNT_BITS-1:0]      out_best_cnt_reg;
    logic                     out_bad_reg;

    logic                    job_accept;
    logic                    out_load;
    scan_ctl_t               scan_ctl;

    logic [TIME_BITS-1:0]    rd_time;
    logic [CNT_BITS-1:0]     rd_cnt;
    logic                    found;
    logic [IDX_BITS-1:0]     first_room;
    logic [CNT_BITS-1:0]     first_cnt;
    logic [IDX_BITS-1:0]     min_room;
    logic [TIME_BITS-1:0]    min_time;
    logic [CNT_BITS-1:0]     min_cnt;
    logic [IDX_BITS-1:0]     best_room;
    logic [CNT_BITS-1:0]     best_cnt;

    logic [IDX_BITS-1:0]     sel_room;
    logic [CNT_BITS-1:0]     sel_cnt;
    logic [CNT_BITS-1:0]     new_cnt;
    logic [TIME_BITS-1:0]    new_time;
    logic [TIME_BITS-1:0]    sel_actual;
    logic [IN_TIME_BITS-1:0] duration;
    logic [TIME_BITS:0]      delayed_sum;
    logic                    take_sel;
    logic                    store_wr;
    logic                    store_clear;

    // active room count and last scanned index
    always_comb
    begin
        active_cnt = 7'(rooms_in_use_reg);
        if (rooms_in_use_reg == '0)
        begin
            active_cnt = 7'd1;
        end
        else if (active_cnt > ROOMS_W)
        begin
            active_cnt = ROOMS_W;
        end
        last_idx = IDX_BITS'(active_cnt - 7'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rooms_in_use_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            rooms_in_use_reg <= cfg_wdata;
        end
    end

    assign job_ch.ready = (state_reg == ST_IDLE);
    assign job_accept   = job_ch.valid && job_ch.ready;
    assign out_load     = (state_reg == ST_DONE) && (!out_valid_reg || res_ch.ready);
    assign store_clear  = job_accept && (job_ch.mode == MODE_CLEAR);
    assign store_wr     = (state_reg == ST_COMMIT) && !bad_reg;

    assign scan_ctl.start = job_accept && (job_ch.mode == MODE_SCHED);
    assign scan_ctl.eval  = eval_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_accept)
                begin
                    addr_next = '0;
                    if (job_ch.mode == MODE_CLEAR)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == last_idx)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
            eval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            eval_reg  <= (state_reg == ST_SCAN);
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= addr_reg;
        if (job_accept)
        begin
            st_reg  <= job_ch.start_time;
            en_reg  <= job_ch.end_time;
            bad_reg <= (job_ch.end_time <= job_ch.start_time);
        end
    end

    lfrs_store #(
        .ROOMS     (ROOMS),
        .TIME_BITS (TIME_BITS),
        .IDX_BITS  (IDX_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (store_clear),
        .wr_en   (store_wr),
        .wr_addr (sel_room),
        .wr_time (new_time),
        .wr_cnt  (new_cnt),
        .rd_addr (addr_reg),
        .rd_time (rd_time),
        .rd_cnt  (rd_cnt)
    );

    lfrs_scan #(
        .TIME_BITS (TIME_BITS),
        .IDX_BITS  (IDX_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .idx        (eval_idx_reg),
        .room_time  (rd_time),
        .room_cnt   (rd_cnt),
        .start_time (TIME_BITS'(st_reg)),
        .found      (found),
        .first_room (first_room),
        .first_cnt  (first_cnt),
        .min_room   (min_room),
        .min_time   (min_time),
        .min_cnt    (min_cnt),
        .best_room  (best_room),
        .best_cnt   (best_cnt)
    );

    // commit: place the job and update the busiest room
    always_comb
    begin
        duration    = en_reg - st_reg;
        delayed_sum = {1'b0, min_time} + (TIME_BITS + 1)'(duration);
        if (found)
        begin
            sel_room   = first_room;
            sel_cnt    = first_cnt;
            sel_actual = TIME_BITS'(st_reg);
            new_time   = TIME_BITS'(en_reg);
        end
        else
        begin
            sel_room   = min_room;
            sel_cnt    = min_cnt;
            sel_actual = min_time;
            new_time   = delayed_sum[TIME_BITS] ? '1 : delayed_sum[TIME_BITS-1:0];
        end
        new_cnt  = (sel_cnt == CNT_MAX) ? sel_cnt : sel_cnt + 1'b1;
        take_sel = (new_cnt > best_cnt) || ((new_cnt == best_cnt) && (sel_room < best_room));
    end

    always_ff @(posedge clk)
    begin
        if (store_clear)
        begin
            res_room_reg      <= '0;
            res_actual_reg    <= '0;
            res_delayed_reg   <= 1'b0;
            res_best_room_reg <= '0;
            res_best_cnt_reg  <= '0;
            res_bad_reg       <= 1'b0;
        end
        else if (state_reg == ST_COMMIT)
        begin
            res_bad_reg <= bad_reg;
            if (bad_reg)
            begin
                res_room_reg      <= '0;
                res_actual_reg    <= '0;
                res_delayed_reg   <= 1'b0;
                res_best_room_reg <= best_room;
                res_best_cnt_reg  <= best_cnt;
            end
            else
            begin
                res_room_reg      <= sel_room;
                res_actual_reg    <= sel_actual;
                res_delayed_reg   <= !found;
                res_best_room_reg <= take_sel ? sel_room : best_room;
                res_best_cnt_reg  <= take_sel ? new_cnt : best_cnt;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_room_reg      <= OUT_ROOM_BITS'(res_room_reg);
            out_actual_reg    <= OUT_TIME_BITS'(res_actual_reg);
            out_delayed_reg   <= res_delayed_reg;
            out_best_room_reg <= OUT_ROOM_BITS'(res_best_room_reg);
            out_best_cnt_reg  <= res_best_cnt_reg;
            out_bad_reg       <= res_bad_reg;
        end
    end

    assign res_ch.valid         = out_valid_reg;
    assign res_ch.assigned_room = out_room_reg;
    assign res_ch.actual_start  = out_actual_reg;
    assign res_ch.was_delayed   = out_delayed_reg;
    assign res_ch.busiest_room  = out_best_room_reg;
    assign res_ch.busiest_count = out_best_cnt_reg;
    assign res_ch.bad_job       = out_bad_reg;

endmodule

>>> hdl/lfrs_port_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrs_port_chk
// Port-level checks of the scheduler core, bound to the core module.
// ----------------------------------------------------------------------------
module lfrs_port_chk
    import lfrs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     job_valid,
    input logic                     job_ready,
    input logic                     res_valid,
    input logic                     res_ready,
    input logic [OUT_ROOM_BITS-1:0] assigned_room,
    input logic [OUT_TIME_BITS-1:0] actual_start,
    input logic                     was_delayed,
    input logic [OUT_ROOM_BITS-1:0] busiest_room,
    input logic [CNT_BITS-1:0]      busiest_count,
    input logic                     bad_job
);

    // stalled result item holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid &&
            $stable({assigned_room, actual_start, was_delayed, busiest_room,
                     busiest_count, bad_job}))
        else $error("result item changed while stalled");

    // one job in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready |=> !job_ready)
        else $error("job accepted while busy");

    // ignored job reports no placement
    a_bad_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && bad_job |-> assigned_room == '0 && actual_start == '0 &&
            !was_delayed)
        else $error("bad job reported a placement");

    // a non-bad item with a zero busiest count is all zero, as after a clear
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !bad_job && busiest_count == '0 |-> assigned_room == '0 &&
            actual_start == '0 && !was_delayed && busiest_room == '0)
        else $error("placed job with zero busiest count");

endmodule

bind lowest_free_room_scheduler_core lfrs_port_chk u_port_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (job_ch.valid),
    .job_ready     (job_ch.ready),
    .res_valid     (res_ch.valid),
    .res_ready     (res_ch.ready),
    .assigned_room (res_ch.assigned_room),
    .actual_start  (res_ch.actual_start),
    .was_delayed   (res_ch.was_delayed),
    .busiest_room  (res_ch.busiest_room),
    .busiest_count (res_ch.busiest_count),
    .bad_job       (res_ch.bad_job)
);

>>> dv/lfrs_sched_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfrs_sched_checker
// Watches the job, result and config ports of the room scheduler. It keeps
// its own per-room free times, use counts and room count, and predicts each
// result from every accepted job. Each accepted result is compared field by
// field against the oldest prediction. Mismatches and unexpected results
// are counted for the testbench top.
// ----------------------------------------------------------------------------
module lfrs_sched_checker
    import lfrs_pkg::*;
#(
    parameter int ROOMS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    lfrs_job_if                 job_ch,
    lfrs_res_if                 res_ch,
    output int                  mismatch_count,
    output int                  results_owed
);

    typedef struct packed {
        logic [OUT_ROOM_BITS-1:0] room;
        logic [OUT_TIME_BITS-1:0] start;
        logic                     delayed;
        logic [OUT_ROOM_BITS-1:0] busy_room;
        logic [CNT_BITS-1:0]      busy_count;
        logic                     bad;
    } sched_result_t;

    logic [OUT_TIME_BITS-1:0] free_at [ROOMS];
    logic [CNT_BITS-1:0]      jobs_in [ROOMS];
    logic [CFG_BITS-1:0]      rooms_cfg;
    sched_result_t            owed_q [$];

    function automatic void clear_rooms();
        for (int i = 0; i < ROOMS; i++)
        begin
            free_at[i] = '0;
            jobs_in[i] = '0;
        end
    endfunction

    function automatic sched_result_t place_job(logic mode, logic [IN_TIME_BITS-1:0] st,
                                                logic [IN_TIME_BITS-1:0] en);
        sched_result_t            r;
        int                       k;
        int                       pick;
        int                       top;
        bit                       found;
        logic [OUT_TIME_BITS:0]   sum;
        logic [IN_TIME_BITS-1:0]  span;

        r = '0;
        k = (rooms_cfg == 0) ? 1 : ((rooms_cfg > ROOMS) ? ROOMS : int'(rooms_cfg));
        if (mode == MODE_CLEAR)
        begin
            clear_rooms();
            return r;
        end
        if (en <= st)
        begin
            r.bad = 1'b1;
        end
        else
        begin
            found = 1'b0;
            pick  = 0;
            for (int i = 0; i < k; i++)
            begin
                if (!found && free_at[i] <= st)
                begin
                    pick  = i;
                    found = 1'b1;
                end
            end
            if (found)
            begin
                r.start       = st;
                free_at[pick] = en;
            end
            else
            begin
                // no room free: earliest freeing room, duration kept
                for (int i = 1; i < k; i++)
                begin
                    if (free_at[i] < free_at[pick])
                        pick = i;
                end
                r.start       = free_at[pick];
                r.delayed     = 1'b1;
                span          = en - st;
                sum           = free_at[pick] + span;
                free_at[pick] = sum[OUT_TIME_BITS] ? '1 : sum[OUT_TIME_BITS-1:0];
            end
            if (jobs_in[pick] != CNT_MAX)
                jobs_in[pick] = jobs_in[pick] + 1'b1;
            r.room = pick[OUT_ROOM_BITS-1:0];
        end
        top = 0;
        for (int i = 1; i < k; i++)
        begin
            if (jobs_in[i] > jobs_in[top])
                top = i;
        end
        r.busy_room  = top[OUT_ROOM_BITS-1:0];
        r.busy_count = jobs_in[top];
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;

        if (!rst_n)
        begin
            clear_rooms();
            rooms_cfg = CFG_RESET;
            owed_q.delete();
            results_owed = 0;
        end
        else
        begin
            if (cfg_we)
                rooms_cfg = cfg_wdata;
            if (res_ch.valid && res_ch.ready)
            begin
                if (owed_q.size() == 0)
                begin
                    $error("result item with no job waiting for it");
                    mismatch_count++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    check_field("assigned_room", want.room, res_ch.assigned_room);
                    check_field("actual_start", want.start, res_ch.actual_start);
                    check_field("was_delayed", want.delayed, res_ch.was_delayed);
                    check_field("busiest_room", want.busy_room, res_ch.busiest_room);
                    check_field("busiest_count", want.busy_count, res_ch.busiest_count);
                    check_field("bad_job", want.bad, res_ch.bad_job);
                end
            end
            if (job_ch.valid && job_ch.ready)
                owed_q.push_back(place_job(job_ch.mode, job_ch.start_time, job_ch.end_time));
            results_owed = owed_q.size();
        end
    end

endmodule

>>> dv/lowest_free_room_scheduler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_free_room_scheduler_core_tb
// Drives jobs into the room scheduler and stalls its result side at random.
// A directed part covers room ties, delays, bad jobs, clears and room count
// extremes; a single-room run chains long delayed jobs; then random phases
// of mostly ascending jobs with various room counts follow.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module lowest_free_room_scheduler_core_tb;
    import lfrs_pkg::*;

    localparam int CHAIN_JOBS  = 45;
    localparam int PHASES      = 8;
    localparam int PHASE_JOBS  = 235;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_BITS-1:0]     cfg_wdata;
    int                      mismatch_count;
    int                      results_owed;
    bit                      calm;
    logic [IN_TIME_BITS-1:0] cursor;

    lfrs_job_if job_ch();
    lfrs_res_if res_ch();

    lowest_free_room_scheduler_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .job_ch    (job_ch),
        .res_ch    (res_ch)
    );

    lfrs_sched_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .job_ch         (job_ch),
        .res_ch         (res_ch),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: stall and run bursts, long runs now and then
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
            begin
                res_ch.ready <= 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(60, 200) - 1) @(negedge clk);
            end
            else
            begin
                res_ch.ready <= ($urandom_range(0, 2) != 0);
                repeat ($urandom_range(1, 14) - 1) @(negedge clk);
            end
        end
    end

    task automatic put_job(logic mode, logic [IN_TIME_BITS-1:0] st,
                           logic [IN_TIME_BITS-1:0] en);
        int unsigned gap;

        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 14);
        @(negedge clk);
        if (gap != 0)
        begin
            job_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        job_ch.valid      <= 1'b1;
        job_ch.mode       <= mode;
        job_ch.start_time <= st;
        job_ch.end_time   <= en;
        do
            @(posedge clk);
        while (!job_ch.ready);
    endtask

    task automatic settle();
        @(negedge clk);
        job_ch.valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_rooms(logic [CFG_BITS-1:0] count);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_job(int unsigned span, int unsigned k);
        int unsigned             pick;
        logic [IN_TIME_BITS-1:0] st;

        pick = $urandom_range(0, 99);
        if (pick < 2)
        begin
            cursor = $urandom_range(0, 32'hF000_0000);
            put_job(MODE_CLEAR, $urandom(), $urandom());
        end
        else if (pick < 8)
        begin
            st = cursor;
            put_job(MODE_SCHED, st, st - $urandom_range(0, 50));
        end
        else if (pick < 11)
        begin
            put_job(MODE_SCHED, $urandom(), $urandom());
        end
        else
        begin
            cursor = cursor + $urandom_range(0, span);
            put_job(MODE_SCHED, cursor, cursor + $urandom_range(1, span * k * 3));
        end
    endtask

    initial
    begin
        logic [CFG_BITS-1:0] count;
        int unsigned         k;
        int unsigned         span;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = CFG_RESET;
        job_ch.valid      = 1'b0;
        job_ch.mode       = MODE_SCHED;
        job_ch.start_time = '0;
        job_ch.end_time   = '0;
        calm              = 1'b0;
        cursor            = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sixteen rooms after reset: lowest free room, bad jobs
        put_job(MODE_SCHED, 32'd0, 32'd1);
        put_job(MODE_SCHED, 32'd0, 32'hFFFF_FFFF);
        put_job(MODE_SCHED, 32'd5, 32'd5);
        put_job(MODE_SCHED, 32'd7, 32'd3);
        put_job(MODE_SCHED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_job(MODE_SCHED, 32'hFFFF_FFFF, 32'd0);
        put_job(MODE_SCHED, 32'd1, 32'd2);
        put_job(MODE_SCHED, 32'd2, 32'd3);

        // one room: delayed job, clear, high start times
        set_rooms(5'd1);
        put_job(MODE_SCHED, 32'd3, 32'd10);
        put_job(MODE_SCHED, 32'd4, 32'd6);
        put_job(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_job(MODE_SCHED, 32'h8000_0000, 32'hFFFF_FFFF);
        put_job(MODE_SCHED, 32'h8000_0001, 32'h8000_0002);

        // two rooms freeing at the same time: lowest one wins
        set_rooms(5'd2);
        put_job(MODE_CLEAR, 32'd0, 32'd0);
        put_job(MODE_SCHED, 32'd0, 32'd100);
        put_job(MODE_SCHED, 32'd0, 32'd100);
        put_job(MODE_SCHED, 32'd5, 32'd6);

        // room count above the room total
        set_rooms(5'd31);
        put_job(MODE_SCHED, 32'd7, 32'd9);
        put_job(MODE_SCHED, 32'd8, 32'h0001_0000);

        // room count zero acts as one: free time grows past 32 bits
        set_rooms(5'd0);
        calm = 1'b1;
        put_job(MODE_CLEAR, 32'd0, 32'd0);
        repeat (CHAIN_JOBS)
            put_job(MODE_SCHED, 32'd0, 32'hFFFF_FFFF);
        put_job(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        calm = 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: count = 5'd16;
                1: count = 5'd1;
                2: count = 5'd31;
                3: count = 5'd0;
                4: count = 5'd17;
                5: count = 5'($urandom_range(2, 15));
                default: count = 5'($urandom_range(0, 31));
            endcase
            k = (count == 0) ? 1 : ((count > 16) ? 16 : count);
            set_rooms(count);
            if (p == PHASES - 1)
                calm = 1'b1;
            case ($urandom_range(0, 3))
                0: span = 1;
                1: span = 10;
                2: span = 1000;
                default: span = 1 << 20;
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                cursor = $urandom_range(0, 32'hF000_0000);
                put_job(MODE_CLEAR, $urandom(), $urandom());
            end
            repeat (PHASE_JOBS)
            begin
                random_job(span, k);
                if ($urandom_range(0, 99) == 0)
                    settle();
            end
        end

        settle();
        repeat (40) @(negedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
hdl/lfrs_pkg.sv
hdl/lfrs_job_if.sv
hdl/lfrs_res_if.sv
hdl/lfrs_store.sv
hdl/lfrs_scan.sv
hdl/lowest_free_room_scheduler_core.sv
hdl/lfrs_port_chk.sv
dv/lfrs_sched_checker.sv
dv/lowest_free_room_scheduler_core_tb.sv
